### hw/rtl/qsf_pkg.sv
// Package for the biquadratic shape function evaluator: widths, constants and node tables.
package qsf_pkg;

  localparam int FRAC_BITS = 14;

  // fixed field widths
  localparam int IN_W   = 16;
  localparam int OUT_W  = 17;
  localparam int NODE_W = 4;

  // internal widths: clamped coordinate, slope, axis product, node product
  localparam int XW   = FRAC_BITS + 2;
  localparam int SW   = FRAC_BITS + 3;
  localparam int PBW  = 2 * XW + 2;
  localparam int EW   = 2 * XW + 1;
  localparam int CMPW = (XW > IN_W + 1) ? XW : IN_W + 1;

  localparam int IN_TDATA_W  = 2 * IN_W;
  localparam int OUT_FIELD_W = NODE_W + 3 * OUT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int NODES = 9;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [1:0]        axis_sel_t;

  localparam node_t LAST_NODE = node_t'(NODES - 1);

  // axis index along xi for each node
  function automatic axis_sel_t axis_a(input node_t k);
    axis_sel_t r;
    case (k)
      4'd0:    r = 2'd0;
      4'd1:    r = 2'd2;
      4'd2:    r = 2'd2;
      4'd3:    r = 2'd0;
      4'd4:    r = 2'd1;
      4'd5:    r = 2'd2;
      4'd6:    r = 2'd1;
      4'd7:    r = 2'd0;
      4'd8:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // axis index along eta for each node
  function automatic axis_sel_t axis_b(input node_t k);
    axis_sel_t r;
    case (k)
      4'd0:    r = 2'd0;
      4'd1:    r = 2'd0;
      4'd2:    r = 2'd2;
      4'd3:    r = 2'd2;
      4'd4:    r = 2'd0;
      4'd5:    r = 2'd1;
      4'd6:    r = 2'd2;
      4'd7:    r = 2'd1;
      4'd8:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/quad9_shape_function_eval.sv
// Top level: 9-node Lagrange shape function evaluator, pipelined with a node sequencer.
//
// Usage: each item on the in_ stream is one coordinate pair (xi, eta) in signed
// Q1.14; values outside [-1,1] are clamped. For every item the out_ stream carries
// nine items, nodes 0 to 8 in element order, each with the shape value and its two
// partial derivatives in signed Q2.14, saturated to [-2,2]; out_tlast marks node 8.
// Results: an item passes stages A, B and C, then each of its results passes D, E
// and F; after the first, the rest follow one per cycle while out_tready is high.
// Throughput: one result per cycle while out_tready stays high; the node
// sequencer feeds the three shared node multipliers with one node a cycle
// unless stage D is held. A new pair is taken while the previous one is still
// being expanded, so back-to-back pairs give an unbroken result stream.
// Stalls: when out_tready is low the pipeline holds and backs up stage by stage;
// in_tready drops while A and B are full and C busy. Nothing is dropped or repeated.
// Reset: rst_n (synchronous, active low) empties all stages; no state is kept
// between items.
module quad9_shape_function_eval (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] coord_xi, [31:16] coord_eta
  input  logic [qsf_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] node_index, [20:4] shape_value, [37:21] deriv_xi, [54:38] deriv_eta,
  // upper bits zero
  output logic [qsf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  localparam int F    = qsf_pkg::FRAC_BITS;
  localparam int XW   = qsf_pkg::XW;
  localparam int SW   = qsf_pkg::SW;
  localparam int PBW  = qsf_pkg::PBW;
  localparam int EW   = qsf_pkg::EW;
  localparam int CMPW = qsf_pkg::CMPW;
  localparam int IW   = qsf_pkg::IN_W;
  localparam int OW   = qsf_pkg::OUT_W;

  localparam logic signed [CMPW-1:0] ONE_C  = CMPW'(2 ** F);
  localparam logic signed [PBW-1:0]  ONE_P  = PBW'(2 ** F);
  localparam logic signed [SW-1:0]   HALF_S = SW'(2 ** (F - 1));
  localparam logic signed [EW-1:0]   TWO_E  = EW'(2 ** (F + 1));

  // clamp a sign-extended coordinate to [-1,1]
  function automatic logic signed [XW-1:0] clamp_coord(input logic signed [CMPW-1:0] v);
    logic signed [CMPW-1:0] t;
    t = v;
    if (v < -ONE_C) begin
      t = -ONE_C;
    end else if (v > ONE_C) begin
      t = ONE_C;
    end
    return t[XW-1:0];
  endfunction

  // unrounded 1D quadratic term: x(x-1), (1-x)(1+x), x(x+1)
  function automatic logic signed [PBW-1:0] axis_prod(input logic signed [XW-1:0] x,
                                                      input logic [1:0] k);
    logic signed [PBW-1:0] xe;
    logic signed [PBW-1:0] r;
    xe = PBW'(x);
    case (k)
      2'd0:    r = xe * (xe - ONE_P);
      2'd1:    r = (ONE_P - xe) * (ONE_P + xe);
      default: r = xe * (xe + ONE_P);
    endcase
    return r;
  endfunction

  // round to nearest, ties upward, dropping s fraction bits
  function automatic logic signed [XW-1:0] round_axis(input logic signed [PBW-1:0] p,
                                                      input int s);
    logic signed [PBW-1:0] q;
    q = p + (PBW'(1) << (s - 1));
    q = q >>> s;
    return q[XW-1:0];
  endfunction

  // round back to Q.F, saturate to [-2,2], cut to field width
  function automatic logic [OW-1:0] round_sat(input logic signed [EW-1:0] p);
    logic signed [EW-1:0] q;
    q = p + (EW'(1) << (F - 1));
    q = q >>> F;
    if (q > TWO_E) begin
      q = TWO_E;
    end else if (q < -TWO_E) begin
      q = -TWO_E;
    end
    return q[OW-1:0];
  endfunction

  // stage valids and node counter
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, f_vld_r;
  logic a_vld_nxt, b_vld_nxt, c_vld_nxt, d_vld_nxt, e_vld_nxt, f_vld_nxt;
  qsf_pkg::node_t cnt_r, cnt_nxt;

  // stage A: clamped coordinates
  logic signed [XW-1:0] a_xi_r, a_eta_r;
  // stage B: raw axis products
  logic signed [PBW-1:0] b_pa_r [3];
  logic signed [PBW-1:0] b_pb_r [3];
  logic signed [XW-1:0]  b_xi_r, b_eta_r;
  // stage C: axis values and slopes, held while the nine nodes go out
  logic signed [XW-1:0] c_va_r [3];
  logic signed [XW-1:0] c_vb_r [3];
  logic signed [SW-1:0] c_sa_r [3];
  logic signed [SW-1:0] c_sb_r [3];
  // stage D: operands of one node
  logic signed [XW-1:0] d_va_r, d_vb_r;
  logic signed [SW-1:0] d_sa_r, d_sb_r;
  qsf_pkg::node_t       d_node_r;
  logic                 d_last_r;
  // stage E: node products
  logic signed [EW-1:0] e_pv_r, e_pdx_r, e_pde_r;
  qsf_pkg::node_t       e_node_r;
  logic                 e_last_r;
  // stage F: output register
  logic [OW-1:0]  f_val_r, f_dxi_r, f_deta_r;
  qsf_pkg::node_t f_node_r;
  logic           f_last_r;

  logic f_rdy, e_rdy, d_rdy, c_rdy, b_rdy, a_rdy;
  logic a_ld, b_ld, c_ld, c_emit, c_done, e_ld, f_ld, out_take;

  logic signed [CMPW-1:0] xi_ext, eta_ext;
  qsf_pkg::axis_sel_t     sel_a, sel_b;

  assign f_rdy    = !f_vld_r || out_tready;
  assign e_rdy    = !e_vld_r || f_rdy;
  assign d_rdy    = !d_vld_r || e_rdy;
  assign c_emit   = c_vld_r && d_rdy;
  assign c_done   = c_emit && (cnt_r == qsf_pkg::LAST_NODE);
  assign c_rdy    = !c_vld_r || c_done;
  assign b_rdy    = !b_vld_r || c_rdy;
  assign a_rdy    = !a_vld_r || b_rdy;

  assign a_ld     = in_tvalid && a_rdy;
  assign b_ld     = a_vld_r && b_rdy;
  assign c_ld     = b_vld_r && c_rdy;
  assign e_ld     = d_vld_r && e_rdy;
  assign f_ld     = e_vld_r && f_rdy;
  assign out_take = f_vld_r && out_tready;

  assign in_tready = a_rdy;

  always_comb begin
    a_vld_nxt = a_ld   || (a_vld_r && !b_ld);
    b_vld_nxt = b_ld   || (b_vld_r && !c_ld);
    c_vld_nxt = c_ld   || (c_vld_r && !c_done);
    d_vld_nxt = c_emit || (d_vld_r && !e_ld);
    e_vld_nxt = e_ld   || (e_vld_r && !f_ld);
    f_vld_nxt = f_ld   || (f_vld_r && !out_take);
    if (c_ld || c_done) begin
      cnt_nxt = '0;
    end else if (c_emit) begin
      cnt_nxt = cnt_r + qsf_pkg::node_t'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      c_vld_r <= c_vld_nxt;
      d_vld_r <= d_vld_nxt;
      e_vld_r <= e_vld_nxt;
      f_vld_r <= f_vld_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign xi_ext  = CMPW'($signed(in_tdata[IW-1:0]));
  assign eta_ext = CMPW'($signed(in_tdata[2*IW-1:IW]));

  always_ff @(posedge clk) begin
    if (a_ld) begin
      a_xi_r  <= clamp_coord(xi_ext);
      a_eta_r <= clamp_coord(eta_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (b_ld) begin
      for (int k = 0; k < 3; k++) begin
        b_pa_r[k] <= axis_prod(a_xi_r, 2'(k));
        b_pb_r[k] <= axis_prod(a_eta_r, 2'(k));
      end
      b_xi_r  <= a_xi_r;
      b_eta_r <= a_eta_r;
    end
  end

  // end terms carry a factor of one half: drop one more bit
  always_ff @(posedge clk) begin
    if (c_ld) begin
      c_va_r[0] <= round_axis(b_pa_r[0], F + 1);
      c_va_r[1] <= round_axis(b_pa_r[1], F);
      c_va_r[2] <= round_axis(b_pa_r[2], F + 1);
      c_vb_r[0] <= round_axis(b_pb_r[0], F + 1);
      c_vb_r[1] <= round_axis(b_pb_r[1], F);
      c_vb_r[2] <= round_axis(b_pb_r[2], F + 1);
      c_sa_r[0] <= SW'(b_xi_r) - HALF_S;
      c_sa_r[1] <= -(SW'(b_xi_r) + SW'(b_xi_r));
      c_sa_r[2] <= SW'(b_xi_r) + HALF_S;
      c_sb_r[0] <= SW'(b_eta_r) - HALF_S;
      c_sb_r[1] <= -(SW'(b_eta_r) + SW'(b_eta_r));
      c_sb_r[2] <= SW'(b_eta_r) + HALF_S;
    end
  end

  assign sel_a = qsf_pkg::axis_a(cnt_r);
  assign sel_b = qsf_pkg::axis_b(cnt_r);

  always_ff @(posedge clk) begin
    if (c_emit) begin
      d_va_r   <= c_va_r[sel_a];
      d_sa_r   <= c_sa_r[sel_a];
      d_vb_r   <= c_vb_r[sel_b];
      d_sb_r   <= c_sb_r[sel_b];
      d_node_r <= cnt_r;
      d_last_r <= (cnt_r == qsf_pkg::LAST_NODE);
    end
  end

  always_ff @(posedge clk) begin
    if (e_ld) begin
      e_pv_r   <= EW'(d_va_r) * EW'(d_vb_r);
      e_pdx_r  <= EW'(d_sa_r) * EW'(d_vb_r);
      e_pde_r  <= EW'(d_va_r) * EW'(d_sb_r);
      e_node_r <= d_node_r;
      e_last_r <= d_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ld) begin
      f_val_r  <= round_sat(e_pv_r);
      f_dxi_r  <= round_sat(e_pdx_r);
      f_deta_r <= round_sat(e_pde_r);
      f_node_r <= e_node_r;
      f_last_r <= e_last_r;
    end
  end

  assign out_tvalid = f_vld_r;
  assign out_tlast  = f_last_r;
  assign out_tdata  = {{qsf_pkg::OUT_PAD_W{1'b0}}, f_deta_r, f_dxi_r, f_val_r, f_node_r};

endmodule
